FILE: src/ltm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing monitor package
// Shared types and constants: request opcodes, statistic selectors,
// register indexes, reset values and the request and result structures.
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned KindW   = 3;
  localparam int unsigned SelW    = 4;
  localparam int unsigned CfgIdxW = 1;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InTdataW  = 80;
  localparam int unsigned OutTdataW = 40;

  localparam logic [DataW-1:0] DeadlineReset = 32'd5000;
  localparam logic [DataW-1:0] StallReset    = 32'd50000;

  typedef enum logic [OpW-1:0] {
    OP_LOOP_BEGIN = 3'd0,
    OP_LOOP_END   = 3'd1,
    OP_STORAGE    = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_READ       = 3'd4
  } ltm_op_e;

  typedef enum logic [SelW-1:0] {
    STAT_COUNT     = 4'd0,
    STAT_GAP_LAST  = 4'd1,
    STAT_GAP_PEAK  = 4'd2,
    STAT_EXEC_LAST = 4'd3,
    STAT_EXEC_PEAK = 4'd4,
    STAT_MISSES    = 4'd5,
    STAT_STALLS    = 4'd6
  } ltm_stat_e;

  // Selector of the storage peak of kind 0; kind k sits at this plus k.
  localparam int unsigned StatStorageBase = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADLINE = 1'd0,
    CFG_STALL    = 1'd1
  } ltm_cfg_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] now_us;
    logic [KindW-1:0] storage_kind;
    logic [DataW-1:0] duration_us;
    logic [SelW-1:0]  stat_select;
  } ltm_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             deadline_miss;
    logic             major_stall;
  } ltm_result_t;

endpackage

FILE: src/ltm_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing monitor input register
// Captures one request and holds it until the statistics stage consumes it.
// ----------------------------------------------------------------------------
module ltm_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ltm_pkg::ltm_item_t in_item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output ltm_pkg::ltm_item_t item_o
);

  logic               valid_q, valid_d;
  ltm_pkg::ltm_item_t item_q;

  // The slot frees up in the same cycle its request moves on.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/ltm_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing monitor statistics
// Holds thresholds and statistics, computes the result of one request and
// commits the state update when the request is consumed.
// ----------------------------------------------------------------------------
module ltm_stats #(
  parameter int unsigned STORAGE_KINDS = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ltm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ltm_pkg::DataW-1:0]    cfg_data_i,
  input  ltm_pkg::ltm_item_t           item_i,
  input  logic                         commit_i,
  output ltm_pkg::ltm_result_t         result_o
);

  localparam int unsigned W = ltm_pkg::DataW;

  logic [W-1:0] deadline_q, stall_q;
  logic [W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic [W-1:0] loops_q, loops_d;
  logic [W-1:0] gap_last_q, gap_last_d, gap_peak_q, gap_peak_d;
  logic [W-1:0] exec_last_q, exec_last_d, exec_peak_q, exec_peak_d;
  logic [W-1:0] miss_q, miss_d, stall_cnt_q, stall_cnt_d;
  logic [W-1:0] peak_q [STORAGE_KINDS];
  logic [W-1:0] peak_d [STORAGE_KINDS];

  logic [W-1:0] gap, exec_time, stat_data, peak_sel;
  logic         gap_valid, over_deadline, over_stall;
  logic [STORAGE_KINDS-1:0] peak_hit;
  ltm_pkg::ltm_op_e op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= ltm_pkg::DeadlineReset;
      stall_q    <= ltm_pkg::StallReset;
    end else if (cfg_we_i) begin
      case (ltm_pkg::ltm_cfg_e'(cfg_index_i))
        ltm_pkg::CFG_DEADLINE: deadline_q <= cfg_data_i;
        ltm_pkg::CFG_STALL:    stall_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign op            = ltm_pkg::ltm_op_e'(item_i.op);
  assign gap           = item_i.now_us - prev_q;
  assign exec_time     = item_i.now_us - cur_q;
  assign gap_valid     = (prev_q != '0);
  assign over_deadline = gap_valid && (gap > deadline_q);
  assign over_stall    = gap_valid && (gap > stall_q);

  // Storage peak read: one lane per kind, combined by an AND-OR select.
  always_comb begin
    peak_sel = '0;
    for (int k = 0; k < STORAGE_KINDS; k++) begin
      if (32'(item_i.stat_select) == 32'(ltm_pkg::StatStorageBase + k)) begin
        peak_sel = peak_sel | peak_q[k];
      end
    end
  end

  always_comb begin
    case (ltm_pkg::ltm_stat_e'(item_i.stat_select))
      ltm_pkg::STAT_COUNT:     stat_data = loops_q;
      ltm_pkg::STAT_GAP_LAST:  stat_data = gap_last_q;
      ltm_pkg::STAT_GAP_PEAK:  stat_data = gap_peak_q;
      ltm_pkg::STAT_EXEC_LAST: stat_data = exec_last_q;
      ltm_pkg::STAT_EXEC_PEAK: stat_data = exec_peak_q;
      ltm_pkg::STAT_MISSES:    stat_data = miss_q;
      ltm_pkg::STAT_STALLS:    stat_data = stall_cnt_q;
      default:                 stat_data = peak_sel;
    endcase
  end

  always_comb begin
    result_o = '0;
    case (op)
      ltm_pkg::OP_LOOP_BEGIN: begin
        result_o.deadline_miss = over_deadline;
        result_o.major_stall   = over_stall;
      end
      ltm_pkg::OP_READ: result_o.read_data = stat_data;
      default: ;
    endcase
  end

  for (genvar k = 0; k < STORAGE_KINDS; k++) begin : g_lane
    assign peak_hit[k] = (32'(item_i.storage_kind) == 32'(k))
                         && (item_i.duration_us > peak_q[k]);
  end

  always_comb begin
    cur_d       = cur_q;
    prev_d      = prev_q;
    loops_d     = loops_q;
    gap_last_d  = gap_last_q;
    gap_peak_d  = gap_peak_q;
    exec_last_d = exec_last_q;
    exec_peak_d = exec_peak_q;
    miss_d      = miss_q;
    stall_cnt_d = stall_cnt_q;
    for (int k = 0; k < STORAGE_KINDS; k++) begin
      peak_d[k] = peak_q[k];
    end
    case (op)
      ltm_pkg::OP_LOOP_BEGIN: begin
        cur_d   = item_i.now_us;
        prev_d  = item_i.now_us;
        loops_d = loops_q + W'(1);
        if (gap_valid) begin
          gap_last_d = gap;
          if (gap > gap_peak_q) begin
            gap_peak_d = gap;
          end
        end
        if (over_deadline) begin
          miss_d = miss_q + W'(1);
        end
        if (over_stall) begin
          stall_cnt_d = stall_cnt_q + W'(1);
        end
      end
      ltm_pkg::OP_LOOP_END: begin
        exec_last_d = exec_time;
        if (exec_time > exec_peak_q) begin
          exec_peak_d = exec_time;
        end
      end
      ltm_pkg::OP_STORAGE: begin
        for (int k = 0; k < STORAGE_KINDS; k++) begin
          if (peak_hit[k]) begin
            peak_d[k] = item_i.duration_us;
          end
        end
      end
      ltm_pkg::OP_CLEAR: begin
        prev_d      = cur_q;
        loops_d     = '0;
        gap_last_d  = '0;
        gap_peak_d  = '0;
        exec_last_d = '0;
        exec_peak_d = '0;
        miss_d      = '0;
        stall_cnt_d = '0;
        for (int k = 0; k < STORAGE_KINDS; k++) begin
          peak_d[k] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      prev_q      <= '0;
      loops_q     <= '0;
      gap_last_q  <= '0;
      gap_peak_q  <= '0;
      exec_last_q <= '0;
      exec_peak_q <= '0;
      miss_q      <= '0;
      stall_cnt_q <= '0;
      for (int k = 0; k < STORAGE_KINDS; k++) begin
        peak_q[k] <= '0;
      end
    end else if (commit_i) begin
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      loops_q     <= loops_d;
      gap_last_q  <= gap_last_d;
      gap_peak_q  <= gap_peak_d;
      exec_last_q <= exec_last_d;
      exec_peak_q <= exec_peak_d;
      miss_q      <= miss_d;
      stall_cnt_q <= stall_cnt_d;
      for (int k = 0; k < STORAGE_KINDS; k++) begin
        peak_q[k] <= peak_d[k];
      end
    end
  end

endmodule

FILE: src/ltm_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing monitor result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ltm_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  output logic                 take_o,
  input  ltm_pkg::ltm_result_t res_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ltm_pkg::ltm_result_t res_o
);

  logic                 valid_q, valid_d;
  ltm_pkg::ltm_result_t res_q;

  // A new result may load when the register is empty or being drained.
  assign take_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/loop_timing_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing monitor core
// Tracks loop gaps, execution times, threshold misses and storage peaks.
// ----------------------------------------------------------------------------
// Every request produces exactly one result, and a request can be accepted
// in every clock cycle while results are taken. A request is captured in an
// input register; while it is held there, a single pass of logic (two 32-bit
// subtracts, a few compares, the counter increments and the statistic select)
// computes its result and commits the state update as the result loads into
// the output register, so each result passes the input and output registers.
// The statistics register is the only loop, so back-to-back requests see each
// other's updates without bubbles. While the result register is full and not
// taken, the input register still accepts one more request before
// s_axis_tready drops. Threshold registers are written on the cfg channel,
// which is always ready; write them only while no request is in flight.
// Loop gaps are measured only once a nonzero previous start is known, all
// differences wrap modulo 2^32, and all counters wrap at 32 bits.
// ----------------------------------------------------------------------------
module loop_timing_monitor_core #(
  parameter int unsigned STORAGE_KINDS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] op, [34:3] now_us, [37:35] storage_kind, [69:38] duration_us,
  // [73:70] stat_select, [79:74] zero.
  input  logic [ltm_pkg::InTdataW-1:0]    s_axis_tdata,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] read_data, [32] deadline_miss, [33] major_stall, [39:34] zero.
  output logic [ltm_pkg::OutTdataW-1:0]   m_axis_tdata,
  // Threshold write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ltm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ltm_pkg::DataW-1:0]       cfg_data_i
);

  ltm_pkg::ltm_item_t   in_item, stage_item;
  ltm_pkg::ltm_result_t stage_res, out_res;
  logic                 stage_valid, out_take, advance;

  // Unpack the request word, first field in the lowest bits.
  assign in_item.op           = s_axis_tdata[2:0];
  assign in_item.now_us       = s_axis_tdata[34:3];
  assign in_item.storage_kind = s_axis_tdata[37:35];
  assign in_item.duration_us  = s_axis_tdata[69:38];
  assign in_item.stat_select  = s_axis_tdata[73:70];

  // The held request completes when the result register can take it.
  assign advance     = stage_valid && out_take;
  assign cfg_ready_o = 1'b1;

  ltm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  ltm_stats #(
    .STORAGE_KINDS (STORAGE_KINDS)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (stage_item),
    .commit_i    (advance),
    .result_o    (stage_res)
  );

  ltm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (stage_valid),
    .take_o      (out_take),
    .res_i       (stage_res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.major_stall, out_res.deadline_miss,
                         out_res.read_data};

endmodule

FILE: tb/sv/loop_timing_monitor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing monitor core testbench
// The testbench sends loop begin, loop end, storage, clear and read requests
// over the request stream. It also sends noise and unused opcodes. It sweeps
// the deadline and stall thresholds through several settings, including the
// extremes. A behavioral predictor computes every result, and each result
// from the stream is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module loop_timing_monitor_core_tb;

  localparam int unsigned StorageKinds   = 6;
  localparam logic [ltm_pkg::OpW-1:0] OpUnusedFirst = 3'd5;
  localparam logic [ltm_pkg::OpW-1:0] OpUnusedLast  = 3'd7;
  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned PressureAt     = 400;
  localparam int unsigned PressureCycles = 300;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ltm_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ltm_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [ltm_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ltm_pkg::DataW-1:0]     cfg_data_i = '0;

  loop_timing_monitor_core #(
    .STORAGE_KINDS(StorageKinds)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the monitor.
  logic [ltm_pkg::DataW-1:0] deadline_limit, stall_limit;
  logic [ltm_pkg::DataW-1:0] cur_start, prev_start, loops, gap_last, gap_peak;
  logic [ltm_pkg::DataW-1:0] exec_last, exec_peak, misses, stalls;
  logic [ltm_pkg::DataW-1:0] storage_peak [StorageKinds];

  ltm_pkg::ltm_item_t   pending_requests [$];
  ltm_pkg::ltm_result_t expected_results [$];
  ltm_pkg::ltm_item_t   offered_req;
  logic [ltm_pkg::DataW-1:0] loop_stamp;

  bit          req_fired, gap_free, pressure_done;
  int unsigned requests_queued, requests_accepted, results_checked;
  int unsigned mismatches, threshold_writes, hold_left, quiet_cycles;

  function automatic void clear_statistics();
    loops = '0;
    gap_last = '0;
    gap_peak = '0;
    exec_last = '0;
    exec_peak = '0;
    misses = '0;
    stalls = '0;
    for (int k = 0; k < StorageKinds; k++) storage_peak[k] = '0;
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic ltm_pkg::ltm_result_t apply_request(ltm_pkg::ltm_item_t r);
    ltm_pkg::ltm_result_t res;
    logic [ltm_pkg::DataW-1:0] span;
    res = '0;
    case (r.op)
      ltm_pkg::OP_LOOP_BEGIN: begin
        cur_start = r.now_us;
        if (prev_start != '0) begin
          span = r.now_us - prev_start;
          gap_last = span;
          if (span > gap_peak) gap_peak = span;
          if (span > deadline_limit) begin
            misses = misses + 1;
            res.deadline_miss = 1'b1;
          end
          if (span > stall_limit) begin
            stalls = stalls + 1;
            res.major_stall = 1'b1;
          end
        end
        prev_start = r.now_us;
        loops = loops + 1;
      end
      ltm_pkg::OP_LOOP_END: begin
        span = r.now_us - cur_start;
        exec_last = span;
        if (span > exec_peak) exec_peak = span;
      end
      ltm_pkg::OP_STORAGE: begin
        if (r.storage_kind < StorageKinds && r.duration_us > storage_peak[r.storage_kind])
          storage_peak[r.storage_kind] = r.duration_us;
      end
      ltm_pkg::OP_CLEAR: begin
        clear_statistics();
        prev_start = cur_start;
      end
      ltm_pkg::OP_READ: begin
        case (r.stat_select)
          ltm_pkg::STAT_COUNT:     res.read_data = loops;
          ltm_pkg::STAT_GAP_LAST:  res.read_data = gap_last;
          ltm_pkg::STAT_GAP_PEAK:  res.read_data = gap_peak;
          ltm_pkg::STAT_EXEC_LAST: res.read_data = exec_last;
          ltm_pkg::STAT_EXEC_PEAK: res.read_data = exec_peak;
          ltm_pkg::STAT_MISSES:    res.read_data = misses;
          ltm_pkg::STAT_STALLS:    res.read_data = stalls;
          default: begin
            if (r.stat_select >= ltm_pkg::StatStorageBase &&
                r.stat_select - ltm_pkg::StatStorageBase < StorageKinds)
              res.read_data = storage_peak[r.stat_select - ltm_pkg::StatStorageBase];
          end
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic ltm_pkg::ltm_item_t request_of(logic [ltm_pkg::OpW-1:0] op,
                                                    logic [ltm_pkg::DataW-1:0] now,
                                                    logic [ltm_pkg::KindW-1:0] kind,
                                                    logic [ltm_pkg::DataW-1:0] dur,
                                                    logic [ltm_pkg::SelW-1:0] sel);
    ltm_pkg::ltm_item_t r;
    r.op = op;
    r.now_us = now;
    r.storage_kind = kind;
    r.duration_us = dur;
    r.stat_select = sel;
    return r;
  endfunction

  function automatic ltm_pkg::ltm_item_t noise_request();
    return request_of($urandom_range(0, 7), $urandom, $urandom_range(0, 7), $urandom,
                      $urandom_range(0, 15));
  endfunction

  function automatic void queue_request(ltm_pkg::ltm_item_t r);
    pending_requests.push_back(r);
    requests_queued++;
  endfunction

  // Gaps cluster around the active thresholds, with wrap and zero gaps mixed in.
  function automatic logic [ltm_pkg::DataW-1:0] pick_gap();
    logic [ltm_pkg::DataW-1:0] thr;
    thr = $urandom_range(0, 1) ? deadline_limit : stall_limit;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return thr + $urandom_range(0, 2) - 32'd1;
      4, 5, 6:    return $urandom_range(0, 20000);
      7:          return 32'hFFFF_FFFF - $urandom_range(0, 100);
      8:          return '0;
      default:    return $urandom;
    endcase
  endfunction

  // Mostly well-formed loop iterations: begin, end, storage records and reads,
  // with occasional clears, zero timestamps and random noise requests.
  task automatic queue_loop_traffic(int unsigned count);
    ltm_pkg::ltm_item_t r;
    int unsigned target;
    target = requests_queued + count;
    while (requests_queued < target) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(noise_request());
      end else begin
        loop_stamp = ($urandom_range(0, 29) == 0) ? '0 : loop_stamp + pick_gap();
        r = noise_request();
        r.op = ltm_pkg::OP_LOOP_BEGIN;
        r.now_us = loop_stamp;
        queue_request(r);
        if ($urandom_range(0, 3) != 0) begin
          r = noise_request();
          r.op = ltm_pkg::OP_LOOP_END;
          r.now_us = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : loop_stamp + $urandom_range(0, 4000);
          queue_request(r);
        end
        repeat ($urandom_range(0, 2)) begin
          r = noise_request();
          r.op = ltm_pkg::OP_STORAGE;
          if ($urandom_range(0, 1)) r.duration_us = $urandom_range(0, 30000);
          queue_request(r);
        end
        repeat ($urandom_range(0, 2)) begin
          r = noise_request();
          r.op = ltm_pkg::OP_READ;
          queue_request(r);
        end
        if ($urandom_range(0, 24) == 0) begin
          r = noise_request();
          r.op = ltm_pkg::OP_CLEAR;
          queue_request(r);
        end
      end
    end
  endtask

  task automatic settle();
    while (requests_accepted != requests_queued || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_threshold(ltm_pkg::ltm_cfg_e idx, logic [ltm_pkg::DataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ltm_pkg::CFG_DEADLINE) deadline_limit = value;
    else stall_limit = value;
    threshold_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Request side: record the accepted request and predict its result.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(apply_request(offered_req));
      requests_accepted++;
      req_fired = 1'b1;
    end
  end

  always @(negedge clk_i) begin : request_drive
    bit offer;
    if (rst_ni && (!s_axis_tvalid || req_fired)) begin
      req_fired = 1'b0;
      offer = pending_requests.size() != 0 && (gap_free || $urandom_range(0, 99) >= 26);
      if (offer) begin
        offered_req = pending_requests.pop_front();
        s_axis_tdata <= {6'b0, offered_req.stat_select, offered_req.duration_us,
                         offered_req.storage_kind, offered_req.now_us, offered_req.op};
      end
      s_axis_tvalid <= offer;
    end
  end

  // Result side: random back-pressure plus one long hold that fills the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!pressure_done && requests_accepted >= PressureAt) begin
        pressure_done = 1'b1;
        hold_left = PressureCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= gap_free || $urandom_range(0, 99) >= 26;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    ltm_pkg::ltm_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.read_data = m_axis_tdata[31:0];
      got.deadline_miss = m_axis_tdata[32];
      got.major_stall = m_axis_tdata[33];
      if (expected_results.size() == 0) begin
        $display("%0t: result %h arrived with no request outstanding", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h, got %h", $time, want.read_data,
                   got.read_data);
          mismatches++;
        end
        if (got.deadline_miss !== want.deadline_miss) begin
          $display("%0t: deadline_miss expected %b, got %b", $time, want.deadline_miss,
                   got.deadline_miss);
          mismatches++;
        end
        if (got.major_stall !== want.major_stall) begin
          $display("%0t: major_stall expected %b, got %b", $time, want.major_stall,
                   got.major_stall);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: nothing moved for %0d cycles, %0d results still due", $time,
                 quiet_cycles, expected_results.size());
        $display("** loop_timing_monitor_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [ltm_pkg::DataW-1:0] dl, st;
    deadline_limit = ltm_pkg::DeadlineReset;
    stall_limit = ltm_pkg::StallReset;
    cur_start = '0;
    prev_start = '0;
    loop_stamp = '0;
    clear_statistics();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset thresholds.
    queue_request(request_of(OpUnusedLast, '1, '1, '1, '1));
    queue_request(request_of(OpUnusedFirst, '0, '0, '0, '0));
    // A zero start leaves no previous start, so the next begin measures nothing.
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'd0, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'd100, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'd5101, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'd10101, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'd60102, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_END, 32'd60101, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_STORAGE, '0, StorageKinds - 1, '1, '0));
    queue_request(request_of(ltm_pkg::OP_STORAGE, '0, StorageKinds + 1, '1, '0));
    queue_request(request_of(ltm_pkg::OP_STORAGE, '0, '0, 32'd1, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'hFFFF_FFF0, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'h0000_0020, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_CLEAR, '0, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0, ltm_pkg::STAT_GAP_PEAK));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0,
                             ltm_pkg::StatStorageBase + StorageKinds - 1));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0, '1));
    queue_request(request_of(ltm_pkg::OP_LOOP_BEGIN, 32'h0000_0030, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0, ltm_pkg::STAT_COUNT));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0, ltm_pkg::STAT_GAP_LAST));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0, ltm_pkg::STAT_EXEC_PEAK));
    queue_request(request_of(ltm_pkg::OP_LOOP_END, 32'h0000_002F, '0, '0, '0));
    queue_request(request_of(ltm_pkg::OP_READ, '0, '0, '0, ltm_pkg::STAT_EXEC_LAST));
    queue_loop_traffic(250);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin dl = '0;        st = '0;        end
        1:       begin dl = '1;        st = '1;        end
        2:       begin dl = 32'd1000;  st = 32'd20000; end
        3:       begin dl = 32'd60000; st = 32'd700;   end
        default: begin dl = $urandom;  st = $urandom;  end
      endcase
      write_threshold(ltm_pkg::CFG_DEADLINE, dl);
      write_threshold(ltm_pkg::CFG_STALL, st);
      gap_free = (p == 2);
      queue_loop_traffic(260);
      settle();
    end
    repeat (5) @(negedge clk_i);

    $display("Sent %0d requests and checked %0d results across 6 threshold settings,",
             requests_accepted, results_checked);
    $display("with %0d threshold writes and one long result back-pressure hold.",
             threshold_writes);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("** loop_timing_monitor_core: PASSED **");
    else
      $display("** loop_timing_monitor_core: FAILED **");
    $finish;
  end

endmodule
